>>> design/bdq_pkg.sv
// bdq_pkg: shared types and constants for the byte deque with word access.
// Field widths, default store depth and the opcode codes. No dependencies.
package bdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int OFFS_W   = 8;
  localparam int FILL_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_FLUSH      = 3'd4,
    OP_WORD_RD    = 3'd5,
    OP_WORD_WR    = 3'd6
  } op_t;

endpackage

>>> design/bdq_store.sv
// bdq_store: circular byte store, two write ports and two registered read ports.
// A word write places both of its bytes in the same cycle.
// Depends on bdq_pkg.
module bdq_store #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bdq_pkg::BYTE_W-1:0] wr_data,
  input  logic                       wr_hi_en,
  input  logic [AW-1:0]              wr_hi_addr,
  input  logic [bdq_pkg::BYTE_W-1:0] wr_hi_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr_a,
  input  logic [AW-1:0]              rd_addr_b,
  output logic [bdq_pkg::BYTE_W-1:0] rd_data_a,
  output logic [bdq_pkg::BYTE_W-1:0] rd_data_b
);
  import bdq_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [BYTE_W-1:0] rd_a_r;
  logic [BYTE_W-1:0] rd_b_r;

  // the two write addresses of a word write are adjacent slots, never equal
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_hi_en) begin
      mem[wr_hi_addr] <= wr_hi_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> design/byte_deque_with_word_access_top.sv
// byte_deque_with_word_access_top: double-ended byte queue with word access.
// Head/count control and result register; storage in bdq_store.
// Depends on bdq_pkg and bdq_store.
//
//   channel | ports                                          | handshake
//   in      | in_opcode in_data_byte in_word_value           | in_valid / in_ready
//           | in_word_offset                                 |
//   out     | out_ok out_out_byte out_out_word out_fill_count| out_valid / out_ready
//
// One transaction per cycle for every opcode unless a held result stalls
// input; the result appears the cycle after acceptance. A word write stores
// both bytes in its accepting cycle through the store's two write ports.
// Synchronous active-low reset empties the deque (head and count to zero).
// A held result stalls input only when out_ready is low.
module byte_deque_with_word_access_top #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [bdq_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [bdq_pkg::WORD_W-1:0]   in_word_value,
  input  logic [bdq_pkg::OFFS_W-1:0]   in_word_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [bdq_pkg::BYTE_W-1:0]   out_out_byte,
  output logic [bdq_pkg::WORD_W-1:0]   out_out_word,
  output logic [bdq_pkg::FILL_W-1:0]   out_fill_count
);
  import bdq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int POSW = OFFS_W + 2;
  localparam int CMPW = (CW > POSW) ? CW : POSW;

  localparam logic [AW:0]   DEPTH_S  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic              out_valid_r;
  logic              ok_r;
  logic              sel_byte_r;
  logic              sel_word_r;
  logic [FILL_W-1:0] fill_r;

  logic accept;
  logic full, empty, word_ok;
  logic ok, sel_byte, sel_word;

  logic [CMPW-1:0] lo_pos, hi_pos;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   tail_slot, last_slot, head_m1, head_p1, lo_slot, hi_slot;

  logic              wr_en, wr_hi_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr_a;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rd_data_a, rd_data_b;

  // store index of a position counted from the front; pos < DEPTH when used
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    full    = (count_r == FULL_CNT);
    empty   = (count_r == '0);
    lo_pos  = CMPW'({in_word_offset, 1'b0});
    hi_pos  = lo_pos + CMPW'(1);
    word_ok = (hi_pos < CMPW'(count_r));
    cnt_m1  = count_r - CW'(1);

    tail_slot = slot_of(head_r, count_r[AW-1:0]);
    last_slot = slot_of(head_r, cnt_m1[AW-1:0]);
    lo_slot   = slot_of(head_r, lo_pos[AW-1:0]);
    hi_slot   = slot_of(head_r, hi_pos[AW-1:0]);
    head_m1   = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
    head_p1   = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok        = 1'b0;
    sel_byte  = 1'b0;
    sel_word  = 1'b0;
    wr_en     = 1'b0;
    wr_hi_en  = 1'b0;
    wr_addr   = tail_slot;
    wr_data   = in_data_byte;
    rd_addr_a = head_r;
    case (op_t'(in_opcode))
      OP_PUSH_BACK: begin
        if (!full) begin
          ok        = 1'b1;
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_BACK: begin
        rd_addr_a = last_slot;
        if (!empty) begin
          ok        = 1'b1;
          sel_byte  = 1'b1;
          count_nxt = cnt_m1;
        end
      end
      OP_PUSH_FRONT: begin
        wr_addr = head_m1;
        if (!full) begin
          ok        = 1'b1;
          wr_en     = 1'b1;
          head_nxt  = head_m1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          ok        = 1'b1;
          sel_byte  = 1'b1;
          head_nxt  = head_p1;
          count_nxt = cnt_m1;
        end
      end
      OP_FLUSH: begin
        ok        = 1'b1;
        head_nxt  = '0;
        count_nxt = '0;
      end
      OP_WORD_RD: begin
        rd_addr_a = lo_slot;
        if (word_ok) begin
          ok       = 1'b1;
          sel_word = 1'b1;
        end
      end
      OP_WORD_WR: begin
        wr_addr = lo_slot;
        wr_data = in_word_value[BYTE_W-1:0];
        if (word_ok) begin
          ok       = 1'b1;
          wr_en    = 1'b1;
          wr_hi_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
    wr_en    = wr_en && accept;
    wr_hi_en = wr_hi_en && accept;
    rd_en    = accept;
  end

  bdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .wr_hi_en   (wr_hi_en),
    .wr_hi_addr (hi_slot),
    .wr_hi_data (in_word_value[WORD_W-1:BYTE_W]),
    .rd_en      (rd_en),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (hi_slot),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r       <= ok;
      sel_byte_r <= sel_byte;
      sel_word_r <= sel_word;
      fill_r     <= FILL_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_out_byte   = sel_byte_r ? rd_data_a : '0;
  assign out_out_word   = sel_word_r ? {rd_data_b, rd_data_a} : '0;
  assign out_fill_count = fill_r;

endmodule
